// ===== src/tpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfc_pkg
// Shared codes, constants and control types of the tilt position controller.
// ----------------------------------------------------------------------------
package tpfc_pkg;

  // request codes
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_SAMPLE = 3'd1;
  localparam logic [2:0] REQ_TICK   = 3'd2;
  localparam logic [2:0] REQ_ABORT  = 3'd3;
  localparam logic [2:0] REQ_FAULT  = 3'd4;

  // move phase
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_SAMPLING = 2'd1;
  localparam logic [1:0] PH_DRIVING  = 2'd2;

  // motor command
  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_FWD  = 2'd1;
  localparam logic [1:0] DRV_REV  = 2'd2;

  // status codes beyond the plain phase
  localparam logic [2:0] ST_SAMPLING = 3'd1;
  localparam logic [2:0] ST_DRIVING  = 3'd2;
  localparam logic [2:0] ST_REACHED  = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;
  localparam logic [2:0] ST_ABORTED  = 3'd5;
  localparam logic [2:0] ST_FAULT    = 3'd6;

  // register indexes
  localparam logic [2:0] REG_TOLERANCE = 3'd0;
  localparam logic [2:0] REG_FINE      = 3'd1;
  localparam logic [2:0] REG_MEDIUM    = 3'd2;
  localparam logic [2:0] REG_COARSE    = 3'd3;
  localparam logic [2:0] REG_HOLD      = 3'd4;
  localparam logic [2:0] REG_TIMEOUT   = 3'd5;

  // register reset values
  localparam logic [14:0] TOLERANCE_RST = 15'd51;
  localparam logic [14:0] FINE_RST      = 15'd384;
  localparam logic [14:0] MEDIUM_RST    = 15'd1280;
  localparam logic [14:0] COARSE_RST    = 15'd3840;
  localparam logic [3:0]  HOLD_RST      = 4'd2;
  localparam logic [15:0] TIMEOUT_RST   = 16'd15;

  // duty steps in percent
  localparam logic [6:0] DUTY_FULL = 7'd100;
  localparam logic [6:0] DUTY_HIGH = 7'd70;
  localparam logic [6:0] DUTY_MID  = 7'd30;
  localparam logic [6:0] DUTY_LOW  = 7'd20;
  localparam logic [6:0] DUTY_OFF  = 7'd0;

  // quadratic calibration y = (A*x*x + B*x + C + 2^31) >> 32
  localparam logic signed [14:0] CAL_A     = 15'sd14521;
  localparam logic signed [32:0] CAL_B     = 33'sd3884025255;
  localparam logic signed [51:0] CAL_C     = 52'sd494028936204;
  localparam logic signed [51:0] CAL_ROUND = 52'sd2147483648;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // handle the accepted word
    logic div;     // average the blend sum
    logic mul1;    // square and linear term
    logic mul2;    // quadratic term
    logic sum;     // add up, round, saturate
    logic eval;    // compare with target, load result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_cal;  // accepted word closes a reading
  } stat_t;

endpackage

// ===== src/tpfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpfc_ctrl
// Sequencer of the tilt controller: handshakes and calibration steps.
// ----------------------------------------------------------------------------
module tpfc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  tpfc_pkg::stat_t stat_i,
  output tpfc_pkg::cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_MUL1 = 6'b000100,
    S_MUL2 = 6'b001000,
    S_SUM  = 6'b010000,
    S_EVAL = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  // take a word only when idle and the result slot frees up
  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // advance through the calibration steps
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && stat_i.need_cal) state_d = S_DIV;
      end
      S_DIV:  state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_SUM;
      S_SUM:  state_d = S_EVAL;
      S_EVAL: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // drive datapath commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = in_acc;
    cmd_o.div    = (state_q == S_DIV);
    cmd_o.mul1   = (state_q == S_MUL1);
    cmd_o.mul2   = (state_q == S_MUL2);
    cmd_o.sum    = (state_q == S_SUM);
    cmd_o.eval   = (state_q == S_EVAL);
  end

  // hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if ((in_acc && !stat_i.need_cal) || (state_q == S_EVAL)) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_cal_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && stat_i.need_cal) |=> (state_q == S_DIV))
    else $error("calibration did not start after closing sample");
  a_eval_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> !out_valid_q)
    else $error("result slot busy when calibrated result loads");
  a_eval_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |=> out_valid_q)
    else $error("calibrated result not presented");
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input taken during calibration");
`endif

endmodule

// ===== src/tpfc_datapath.sv =====
// ----------------------------------------------------------------------------
// tpfc_datapath
// Move state, register file, blend and calibration arithmetic, result word.
// ----------------------------------------------------------------------------
module tpfc_datapath #(
  parameter int SAMPLES_PER_READING = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpfc_pkg::cmd_t     cmd_i,
  output tpfc_pkg::stat_t    stat_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [2:0]         req_type_i,
  input  logic signed [15:0] setpoint_i,
  input  logic signed [15:0] roll_i,
  input  logic signed [15:0] stable_roll_i,
  output logic [1:0]         drive_o,
  output logic [6:0]         duty_percent_o,
  output logic [2:0]         status_o,
  output logic signed [15:0] measured_angle_o
);

  localparam int CntW = $clog2(SAMPLES_PER_READING + 1);
  localparam int SumW = 16 + $clog2(SAMPLES_PER_READING);
  // reciprocal of the sample count, exact for sums below 2^SumW
  localparam int DivK = SumW + 3;
  localparam longint DivM =
    ((longint'(1) << DivK) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING;
  localparam logic [DivK:0]   DivMul  = (DivK + 1)'(DivM);
  localparam logic [SumW-1:0] DivBias = SumW'(SAMPLES_PER_READING * 32768);
  localparam logic [CntW-1:0] CntLast = CntW'(SAMPLES_PER_READING);

  // configuration registers
  logic [14:0] tolerance_q, fine_q, medium_q, coarse_q;
  logic [3:0]  hold_q;
  logic [15:0] timeout_q;

  // move state
  logic [1:0]             phase_q, phase_d;
  logic signed [15:0]     target_q, target_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [3:0]             settled_q, settled_d;
  logic [15:0]            elapsed_q, elapsed_d;
  logic signed [15:0]     angle_q, angle_d;
  logic                   abort_q, abort_d;
  logic [1:0]             drv_q, drv_d;
  logic [6:0]             duty_q, duty_d;

  // calibration pipeline
  logic [SumW-1:0]        u_q;
  logic signed [15:0]     x_q;
  logic signed [31:0]     x2_q;
  logic signed [48:0]     bx_q;
  logic signed [46:0]     ax2_q;

  // result word
  logic [1:0]  drive_q;
  logic [6:0]  duty_out_q;
  logic [2:0]  status_q, status_d;
  logic        out_load;

  // blend and accumulate
  logic signed [17:0]     blend_raw;
  logic signed [15:0]     blend;
  logic signed [SumW-1:0] sum_add;
  logic [CntW-1:0]        cnt_inc;
  logic                   closing;

  assign blend_raw = $signed({roll_i[15], roll_i, 1'b0})
                   + $signed({{2{roll_i[15]}}, roll_i})
                   + $signed({{2{stable_roll_i[15]}}, stable_roll_i});
  assign blend     = blend_raw[17:2];
  assign sum_add   = sum_q + SumW'(blend);
  assign cnt_inc   = cnt_q + CntW'(1);
  assign closing   = (req_type_i == tpfc_pkg::REQ_SAMPLE) && (phase_q != tpfc_pkg::PH_IDLE)
                     && (cnt_inc >= CntLast);
  assign stat_o.need_cal = closing;

  // average by reciprocal multiply on the biased sum
  logic [SumW+DivK:0] div_prod;
  logic [15:0]        div_avg;
  assign div_prod = u_q * DivMul;
  assign div_avg  = div_prod[DivK +: 16];

  // add up the calibration terms, round and saturate
  logic signed [51:0] cal_t;
  logic signed [19:0] cal_y;
  logic signed [15:0] cal_sat;
  assign cal_t = 52'(ax2_q) + 52'(bx_q) + tpfc_pkg::CAL_C + tpfc_pkg::CAL_ROUND;
  assign cal_y = cal_t[51:32];
  always_comb begin
    if (cal_y > 20'sd32767)       cal_sat = 16'sh7fff;
    else if (cal_y < -20'sd32768) cal_sat = 16'sh8000;
    else                          cal_sat = cal_y[15:0];
  end

  // error against target
  logic signed [16:0] err;
  logic [16:0]        mag;
  logic [3:0]         settled_inc;
  assign err         = 17'(target_q) - 17'(angle_q);
  assign mag         = err[16] ? 17'(-err) : 17'(err);
  assign settled_inc = (settled_q < 4'd15) ? settled_q + 4'd1 : settled_q;

  // next move state and status
  always_comb begin
    phase_d   = phase_q;
    target_d  = target_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    settled_d = settled_q;
    elapsed_d = elapsed_q;
    angle_d   = angle_q;
    abort_d   = abort_q;
    drv_d     = drv_q;
    duty_d    = duty_q;
    status_d  = {1'b0, phase_q};
    out_load  = 1'b0;

    if (cmd_i.accept) begin
      out_load = !closing;
      unique case (req_type_i)
        tpfc_pkg::REQ_START: begin
          drv_d  = tpfc_pkg::DRV_STOP;
          duty_d = tpfc_pkg::DUTY_OFF;
          if (abort_q) begin
            abort_d  = 1'b0;
            phase_d  = tpfc_pkg::PH_IDLE;
            status_d = tpfc_pkg::ST_ABORTED;
          end else begin
            target_d  = setpoint_i;
            sum_d     = '0;
            cnt_d     = '0;
            settled_d = '0;
            elapsed_d = '0;
            phase_d   = tpfc_pkg::PH_SAMPLING;
            status_d  = tpfc_pkg::ST_SAMPLING;
          end
        end
        tpfc_pkg::REQ_SAMPLE: begin
          if (phase_q != tpfc_pkg::PH_IDLE) begin
            if (closing) begin
              sum_d = '0;
              cnt_d = '0;
            end else begin
              sum_d = sum_add;
              cnt_d = cnt_inc;
            end
          end
        end
        tpfc_pkg::REQ_TICK: begin
          if (phase_q != tpfc_pkg::PH_IDLE && elapsed_q != 16'hffff)
            elapsed_d = elapsed_q + 16'd1;
        end
        tpfc_pkg::REQ_ABORT: begin
          if (phase_q != tpfc_pkg::PH_IDLE) begin
            drv_d    = tpfc_pkg::DRV_STOP;
            duty_d   = tpfc_pkg::DUTY_OFF;
            phase_d  = tpfc_pkg::PH_IDLE;
            status_d = tpfc_pkg::ST_ABORTED;
          end else begin
            abort_d = 1'b1;
          end
        end
        tpfc_pkg::REQ_FAULT: begin
          if (phase_q != tpfc_pkg::PH_IDLE) begin
            drv_d    = tpfc_pkg::DRV_STOP;
            duty_d   = tpfc_pkg::DUTY_OFF;
            phase_d  = tpfc_pkg::PH_IDLE;
            status_d = tpfc_pkg::ST_FAULT;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.sum) angle_d = cal_sat;

    if (cmd_i.eval) begin
      out_load = 1'b1;
      if (mag <= 17'(tolerance_q)) begin
        settled_d = settled_inc;
        if (settled_inc >= hold_q) begin
          drv_d    = tpfc_pkg::DRV_STOP;
          duty_d   = tpfc_pkg::DUTY_OFF;
          phase_d  = tpfc_pkg::PH_IDLE;
          status_d = tpfc_pkg::ST_REACHED;
        end
      end else begin
        settled_d = '0;
        if (mag > 17'(coarse_q))      duty_d = tpfc_pkg::DUTY_FULL;
        else if (mag > 17'(medium_q)) duty_d = tpfc_pkg::DUTY_HIGH;
        else if (mag > 17'(fine_q))   duty_d = tpfc_pkg::DUTY_MID;
        else                          duty_d = tpfc_pkg::DUTY_LOW;
        drv_d    = (err > 17'sd0) ? tpfc_pkg::DRV_FWD : tpfc_pkg::DRV_REV;
        phase_d  = tpfc_pkg::PH_DRIVING;
        status_d = tpfc_pkg::ST_DRIVING;
        if (elapsed_q >= timeout_q) begin
          drv_d    = tpfc_pkg::DRV_STOP;
          duty_d   = tpfc_pkg::DUTY_OFF;
          phase_d  = tpfc_pkg::PH_IDLE;
          status_d = tpfc_pkg::ST_TIMEOUT;
        end
      end
    end
  end

  // move state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tpfc_pkg::PH_IDLE;
      target_q  <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      settled_q <= '0;
      elapsed_q <= '0;
      angle_q   <= '0;
      abort_q   <= 1'b0;
      drv_q     <= tpfc_pkg::DRV_STOP;
      duty_q    <= tpfc_pkg::DUTY_OFF;
    end else begin
      phase_q   <= phase_d;
      target_q  <= target_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      settled_q <= settled_d;
      elapsed_q <= elapsed_d;
      angle_q   <= angle_d;
      abort_q   <= abort_d;
      drv_q     <= drv_d;
      duty_q    <= duty_d;
    end
  end

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= tpfc_pkg::TOLERANCE_RST;
      fine_q      <= tpfc_pkg::FINE_RST;
      medium_q    <= tpfc_pkg::MEDIUM_RST;
      coarse_q    <= tpfc_pkg::COARSE_RST;
      hold_q      <= tpfc_pkg::HOLD_RST;
      timeout_q   <= tpfc_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tpfc_pkg::REG_TOLERANCE: tolerance_q <= cfg_data_i[14:0];
        tpfc_pkg::REG_FINE:      fine_q      <= cfg_data_i[14:0];
        tpfc_pkg::REG_MEDIUM:    medium_q    <= cfg_data_i[14:0];
        tpfc_pkg::REG_COARSE:    coarse_q    <= cfg_data_i[14:0];
        tpfc_pkg::REG_HOLD:      hold_q      <= cfg_data_i[3:0];
        tpfc_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // calibration pipeline, one step per command
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && closing) u_q <= sum_add + DivBias;
    if (cmd_i.div)  x_q   <= $signed({~div_avg[15], div_avg[14:0]});
    if (cmd_i.mul1) begin
      x2_q <= x_q * x_q;
      bx_q <= tpfc_pkg::CAL_B * x_q;
    end
    if (cmd_i.mul2) ax2_q <= tpfc_pkg::CAL_A * x2_q;
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      drive_q    <= drv_d;
      duty_out_q <= duty_d;
      status_q   <= status_d;
    end
  end

  assign drive_o          = drive_q;
  assign duty_percent_o   = duty_out_q;
  assign status_o         = status_q;
  assign measured_angle_o = angle_q;

endmodule

// ===== src/tilt_position_feedback_controller.sv =====
// ----------------------------------------------------------------------------
// tilt_position_feedback_controller
// Drives a tilt actuator toward a target angle from averaged, calibrated
// roll readings, with tolerance hold, duty windows, timeout and abort.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_stall_o  | req_type, setpoint,
//           |           |                        | roll, stable_roll
//   out     | output    | out_valid_o/out_stall_i| drive, duty_percent,
//           |           |                        | status, measured_angle
//   cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// A word that does not close a reading has its result registered, and it shows
// the next cycle. The sample that closes a reading runs average, two multiplier
// steps, sum and compare before its result shows.
// The input is stalled during that calibration and while a result waits.
// Reset clears the move state and loads the register defaults.
// ----------------------------------------------------------------------------
module tilt_position_feedback_controller #(
  parameter int SAMPLES_PER_READING = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [15:0] setpoint_i,
  input  logic signed [15:0] roll_i,
  input  logic signed [15:0] stable_roll_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         drive_o,
  output logic [6:0]         duty_percent_o,
  output logic [2:0]         status_o,
  output logic signed [15:0] measured_angle_o
);

  tpfc_pkg::cmd_t  cmd;
  tpfc_pkg::stat_t stat;

  // sequencer
  tpfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  tpfc_datapath #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .setpoint_i       (setpoint_i),
    .roll_i           (roll_i),
    .stable_roll_i    (stable_roll_i),
    .drive_o          (drive_o),
    .duty_percent_o   (duty_percent_o),
    .status_o         (status_o),
    .measured_angle_o (measured_angle_o)
  );

endmodule

// ===== sim/tpfc_report_checker.sv =====
// ----------------------------------------------------------------------------
// tpfc_report_checker
// Watches the request and report channels of the tilt position controller,
// predicts one motor report per accepted request word from its own copy of
// the move state and registers, and compares every accepted report field by
// field with the oldest prediction. Hands a failure count to the testbench.
// ----------------------------------------------------------------------------
module tpfc_report_checker
  import tpfc_pkg::*;
#(
  parameter int SAMPLES_PER_READING = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         req_type_i,
  input  logic signed [15:0] setpoint_i,
  input  logic signed [15:0] roll_i,
  input  logic signed [15:0] stable_roll_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         drive_i,
  input  logic [6:0]         duty_percent_i,
  input  logic [2:0]         status_i,
  input  logic signed [15:0] measured_angle_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         drive;
    logic [6:0]         duty;
    logic [2:0]         status;
    logic signed [15:0] angle;
  } motor_report_t;

  // quadratic calibration terms, all scaled to 2^32
  localparam longint QUAD_GAIN   = 64'sd14521;
  localparam longint LIN_GAIN    = 64'sd3884025255;
  localparam longint OFFSET_TERM = 64'sd494028936204;
  localparam longint HALF_LSB    = 64'sd2147483648;

  // register copies
  logic [14:0] tol_band, fine_lim, mid_lim, coarse_lim;
  logic [3:0]  hold_goal;
  logic [15:0] timeout_lim;

  // move state copies
  logic [1:0]         move_phase;
  logic signed [15:0] goal_angle;
  logic signed [15:0] shown_angle;
  int                 reading_sum;
  int                 samples_in;
  int                 in_band_count;
  int                 move_seconds;
  logic               abort_armed;
  logic [1:0]         motor_cmd;
  logic [6:0]         motor_duty;

  motor_report_t expected_reports[$];
  motor_report_t want, got;
  int            mismatches;
  int            checked;

  // Map an averaged blend to a calibrated angle, rounded and saturated
  function automatic logic signed [15:0] calibrated_angle(input int avg);
    longint xl, acc;
    logic signed [15:0] y;
    xl  = avg;
    acc = QUAD_GAIN * xl * xl + LIN_GAIN * xl + OFFSET_TERM + HALF_LSB;
    acc = acc >>> 32;
    if (acc > 32767) y = 16'sh7fff;
    else if (acc < -32768) y = 16'sh8000;
    else y = 16'(acc);
    return y;
  endfunction

  function automatic void halt_motor();
    motor_cmd  = DRV_STOP;
    motor_duty = DUTY_OFF;
  endfunction

  // Judge a finished reading against the target and pick the motor command
  function automatic logic [2:0] judge_reading();
    int err, mag;
    logic [2:0] st;
    err = int'(goal_angle) - int'(shown_angle);
    mag = (err < 0) ? -err : err;
    if (mag <= int'(tol_band)) begin
      if (in_band_count < 15) in_band_count++;
      if (in_band_count >= int'(hold_goal)) begin
        halt_motor();
        move_phase = PH_IDLE;
        st = ST_REACHED;
      end else begin
        st = {1'b0, move_phase};
      end
      return st;
    end
    in_band_count = 0;
    if (mag > int'(coarse_lim)) motor_duty = DUTY_FULL;
    else if (mag > int'(mid_lim)) motor_duty = DUTY_HIGH;
    else if (mag > int'(fine_lim)) motor_duty = DUTY_MID;
    else motor_duty = DUTY_LOW;
    motor_cmd  = (err > 0) ? DRV_FWD : DRV_REV;
    move_phase = PH_DRIVING;
    if (move_seconds >= int'(timeout_lim)) begin
      halt_motor();
      move_phase = PH_IDLE;
      st = ST_TIMEOUT;
    end else begin
      st = ST_DRIVING;
    end
    return st;
  endfunction

  // Advance the move state by one request word and build its report
  function automatic motor_report_t next_report(input logic [2:0] req,
                                                input logic signed [15:0] tgt,
                                                input logic signed [15:0] r,
                                                input logic signed [15:0] s);
    motor_report_t rep;
    logic [2:0] st;
    int blend, avg;
    st = {1'b0, move_phase};
    case (req)
      REQ_START: begin
        halt_motor();
        if (abort_armed) begin
          abort_armed = 1'b0;
          move_phase  = PH_IDLE;
          st          = ST_ABORTED;
        end else begin
          goal_angle    = tgt;
          reading_sum   = 0;
          samples_in    = 0;
          in_band_count = 0;
          move_seconds  = 0;
          move_phase    = PH_SAMPLING;
          st            = ST_SAMPLING;
        end
      end
      REQ_SAMPLE: begin
        if (move_phase != PH_IDLE) begin
          blend       = 3 * int'(r) + int'(s);
          reading_sum = reading_sum + (blend >>> 2);
          samples_in  = (samples_in + 1) & 15;
          if (samples_in >= SAMPLES_PER_READING) begin
            avg = reading_sum / SAMPLES_PER_READING;
            if ((reading_sum % SAMPLES_PER_READING) != 0 && reading_sum < 0) avg--;
            shown_angle = calibrated_angle(avg);
            reading_sum = 0;
            samples_in  = 0;
            st          = judge_reading();
          end
        end
      end
      REQ_TICK: begin
        if (move_phase != PH_IDLE && move_seconds < 65535) move_seconds++;
      end
      REQ_ABORT: begin
        if (move_phase != PH_IDLE) begin
          halt_motor();
          move_phase = PH_IDLE;
          st         = ST_ABORTED;
        end else begin
          abort_armed = 1'b1;
        end
      end
      REQ_FAULT: begin
        if (move_phase != PH_IDLE) begin
          halt_motor();
          move_phase = PH_IDLE;
          st         = ST_FAULT;
        end
      end
      default: begin
      end
    endcase
    rep.drive  = motor_cmd;
    rep.duty   = motor_duty;
    rep.status = st;
    rep.angle  = shown_angle;
    return rep;
  endfunction

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      mismatches++;
      $display("%0t: report %0d %s expected %0d, got %0d",
               $time, checked, field, want_v, got_v);
    end
  endtask

  // Compare accepted reports, mirror register writes, predict accepted requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_band      = TOLERANCE_RST;
      fine_lim      = FINE_RST;
      mid_lim       = MEDIUM_RST;
      coarse_lim    = COARSE_RST;
      hold_goal     = HOLD_RST;
      timeout_lim   = TIMEOUT_RST;
      move_phase    = PH_IDLE;
      goal_angle    = '0;
      shown_angle   = '0;
      reading_sum   = 0;
      samples_in    = 0;
      in_band_count = 0;
      move_seconds  = 0;
      abort_armed   = 1'b0;
      motor_cmd     = DRV_STOP;
      motor_duty    = DUTY_OFF;
      mismatches    = 0;
      checked       = 0;
      expected_reports.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.drive  = drive_i;
        got.duty   = duty_percent_i;
        got.status = status_i;
        got.angle  = measured_angle_i;
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t: report word with nothing expected, status %0d angle %0d",
                   $time, status_i, measured_angle_i);
        end else begin
          want = expected_reports.pop_front();
          check_field("drive", int'(want.drive), int'(got.drive));
          check_field("duty_percent", int'(want.duty), int'(got.duty));
          check_field("status", int'(want.status), int'(got.status));
          check_field("measured_angle", int'(want.angle), int'(got.angle));
          checked++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TOLERANCE: tol_band    = cfg_data_i[14:0];
          REG_FINE:      fine_lim    = cfg_data_i[14:0];
          REG_MEDIUM:    mid_lim     = cfg_data_i[14:0];
          REG_COARSE:    coarse_lim  = cfg_data_i[14:0];
          REG_HOLD:      hold_goal   = cfg_data_i[3:0];
          REG_TIMEOUT:   timeout_lim = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_reports.push_back(next_report(req_type_i, setpoint_i,
                                               roll_i, stable_roll_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_reports.size();
      checked_o    <= checked;
    end
  end

endmodule

// ===== sim/tilt_position_feedback_controller_tb.sv =====
// ----------------------------------------------------------------------------
// tilt_position_feedback_controller_tb
// Drives directed corner cases and then randomized moves (start, sensor
// readings converging on the target, second ticks, aborts and faults, plus
// noise words) through the controller under several register settings, with
// random idling on both channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tilt_position_feedback_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpfc_pkg::*;

  localparam int         SAMPLES          = 3;
  localparam int         WORDS_PER_SETTING = 260;
  localparam int         SETTING_COUNT    = 6;
  localparam logic [2:0] REQ_UNUSED       = 3'd5;
  localparam logic [2:0] REG_ORDER [6] = '{REG_TOLERANCE, REG_FINE, REG_MEDIUM,
                                           REG_COARSE, REG_HOLD, REG_TIMEOUT};

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         req_type;
  logic signed [15:0] setpoint;
  logic signed [15:0] roll;
  logic signed [15:0] stable_roll;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         drive;
  logic [6:0]         duty_percent;
  logic [2:0]         status;
  logic signed [15:0] measured_angle;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;

  tilt_position_feedback_controller #(
    .SAMPLES_PER_READING(SAMPLES)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .setpoint_i      (setpoint),
    .roll_i          (roll),
    .stable_roll_i   (stable_roll),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .drive_o         (drive),
    .duty_percent_o  (duty_percent),
    .status_o        (status),
    .measured_angle_o(measured_angle)
  );

  tpfc_report_checker #(
    .SAMPLES_PER_READING(SAMPLES)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .req_type_i      (req_type),
    .setpoint_i      (setpoint),
    .roll_i          (roll),
    .stable_roll_i   (stable_roll),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .drive_i         (drive),
    .duty_percent_i  (duty_percent),
    .status_i        (status),
    .measured_angle_i(measured_angle),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the report channel at random
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic signed [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] to_q88(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Offer one request word, hold it until accepted
  task automatic send_word(input logic [2:0] req, input logic signed [15:0] tgt,
                           input logic signed [15:0] r, input logic signed [15:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    setpoint     <= tgt;
    roll         <= r;
    stable_roll  <= s;
    do @(posedge clk_i); while (in_stall);
    words_sent++;
  endtask

  task automatic send_reading(input logic signed [15:0] r, input logic signed [15:0] s);
    repeat (SAMPLES) send_word(REQ_SAMPLE, rand16(), r, s);
  endtask

  // Pause the sender until every predicted report has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_registers(input logic [15:0] tol, input logic [15:0] fine,
                                input logic [15:0] med, input logic [15:0] coarse,
                                input logic [15:0] hold, input logic [15:0] tmo);
    logic [15:0] vals [6];
    vals = '{tol, fine, med, coarse, hold, tmo};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input int k);
    int fine, med;
    case (k)
      0: load_registers(80, 300, 1000, 3000, 3, 30);
      1: load_registers(0, 0, 0, 0, 15, 65535);
      2: load_registers(32767, 32767, 32767, 32767, 1, 1);
      3: begin
        fine = $urandom_range(100, 1000);
        med  = fine + $urandom_range(0, 2000);
        load_registers(16'($urandom_range(20, 200)), 16'(fine), 16'(med),
                       16'(med + $urandom_range(0, 4000)),
                       16'($urandom_range(1, 6)), 16'($urandom_range(5, 60)));
      end
      4: load_registers(40, 3000, 1500, 500, 2, 20);
      default: load_registers(16'(TOLERANCE_RST), 16'(FINE_RST), 16'(MEDIUM_RST),
                              16'(COARSE_RST), 16'(HOLD_RST), TIMEOUT_RST);
    endcase
  endtask

  // Insert a second tick now and then, sometimes a burst to force timeouts
  task automatic maybe_tick();
    int dice;
    dice = $urandom_range(0, 99);
    if (dice < 20) send_word(REQ_TICK, rand16(), rand16(), rand16());
    else if (dice < 24) repeat ($urandom_range(5, 20)) send_word(REQ_TICK, rand16(),
                                                                   rand16(), rand16());
  endtask

  // Run one move: start, then readings closing in on the target position
  task automatic run_move();
    int goal, rest, pos, spread, dice;
    if ($urandom_range(0, 9) == 0) goal = $urandom_range(0, 65535) - 32768;
    else goal = $urandom_range(0, 8000) - 4000;
    // rough inverse of the calibration near zero
    rest = ((goal - 115) * 283) >>> 8;
    case ($urandom_range(0, 3))
      0: spread = 50;
      1: spread = 600;
      2: spread = 2000;
      default: spread = 8000;
    endcase
    pos = rest + $urandom_range(0, 2 * spread) - spread;
    send_word(REQ_START, to_q88(goal), rand16(), rand16());
    repeat ($urandom_range(1, 8)) begin
      repeat (SAMPLES) begin
        maybe_tick();
        send_word(REQ_SAMPLE, rand16(), to_q88(pos + $urandom_range(0, 16) - 8),
                  to_q88(pos + $urandom_range(0, 16) - 8));
      end
      pos = pos + (rest - pos) / 2;
      dice = $urandom_range(0, 99);
      if (dice < 2) send_word(REQ_ABORT, rand16(), rand16(), rand16());
      else if (dice < 3) send_word(REQ_FAULT, rand16(), rand16(), rand16());
      else if (dice < 5) send_word(REQ_START, to_q88(goal), rand16(), rand16());
    end
  endtask

  initial begin
    int first_word, dice;
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_TOLERANCE;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    req_type     <= REQ_TICK;
    setpoint     <= '0;
    roll         <= '0;
    stable_roll  <= '0;
    out_stall    <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle corner cases: ignored words, abort held for the next start
    send_word(REQ_TICK, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_word(REQ_SAMPLE, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_word(REQ_FAULT, '0, '0, '0);
    send_word(REQ_UNUSED, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_word(REQ_ABORT, '0, '0, '0);
    send_word(REQ_START, 16'sd100, '0, '0);
    // full-scale readings: calibration saturates, then fault while moving
    send_word(REQ_START, 16'sh7fff, '0, '0);
    send_reading(16'sh7fff, 16'sh7fff);
    send_word(REQ_FAULT, '0, '0, '0);
    // most negative readings drive in reverse, then abort while moving
    send_word(REQ_START, 16'sh8000, '0, '0);
    send_reading(16'sh8000, 16'sh8000);
    send_word(REQ_TICK, '0, '0, '0);
    send_word(REQ_ABORT, '0, '0, '0);
    // zero hold count and zero timeout
    wait_results_drained();
    load_registers(16'(TOLERANCE_RST), 16'(FINE_RST), 16'(MEDIUM_RST), 16'(COARSE_RST),
                   '0, '0);
    send_word(REQ_START, 16'sd115, '0, '0);
    send_reading('0, '0);
    send_word(REQ_START, 16'sd5000, '0, '0);
    send_reading('0, '0);

    // randomized moves under each register setting
    for (int k = 0; k < SETTING_COUNT; k++) begin
      wait_results_drained();
      apply_setting(k);
      if (k < 2) begin
        send_idle_pct = 11;
        stall_pct     = 82;
      end else if (k < 4) begin
        send_idle_pct = 82;
        stall_pct     = 11;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      first_word = words_sent;
      while (words_sent - first_word < WORDS_PER_SETTING) begin
        dice = $urandom_range(0, 99);
        if (dice < 85) run_move();
        else if (dice < 95) send_word(3'($urandom_range(0, 7)), rand16(), rand16(), rand16());
        else send_word(REQ_ABORT, rand16(), rand16(), rand16());
      end
    end

    wait_results_drained();
    $display("run covered %0d request words over %0d register settings plus defaults",
             words_sent, SETTING_COUNT);
    $display("idling sender-heavy, receiver-heavy and none; %0d reports checked, %0d bad",
             checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tilt_position_feedback_controller verification clean");
    end else begin
      $display("tilt_position_feedback_controller verification failed");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #2ms;
    $display("tilt_position_feedback_controller verification failed");
    $finish;
  end

endmodule
